@@ design/qvr_pkg.sv @@
// shared constants for the quaternion vector rotation block
// no dependencies
package qvr_pkg;

  // default width of every data field
  localparam int DATA_WIDTH_DEF = 32;

  // operand slice width of the pipelined multiplier
  localparam int MUL_CHUNK = 32;

endpackage

@@ design/qvr_if.sv @@
// valid/ready channel interfaces for item and result transfers
// depends on qvr_pkg for the default field width
interface qvr_in_if #(
  parameter int W = qvr_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic signed [W-1:0] vec_x;
  logic signed [W-1:0] vec_y;
  logic signed [W-1:0] vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qvr_out_if #(
  parameter int W = qvr_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic signed [W-1:0] out_z;
  logic                saturated;
  logic                zero_quat;

  modport source (
    output valid, out_x, out_y, out_z, saturated, zero_quat,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, saturated, zero_quat,
    output ready
  );
endinterface

@@ design/quaternion_vector_rotation_top.sv @@
// quaternion frame rotation of a 3-vector, fully pipelined
// depends on qvr_pkg, qvr_if, qvr_mul and qvr_div
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  item    | in  | quat_w quat_x quat_y quat_z (Q1.30), vec_x vec_y vec_z (Q15.16)
//  result  | out | out_x out_y out_z (Q15.16), saturated, zero_quat
//
// one item per cycle unless the result stalls; depth is set mostly by the
// divider pipeline that retires one quotient bit per stage (DATA_WIDTH + 3)
// reset clears only the valid bits; payload registers are not reset
// a stalled result freezes every stage at once, so nothing is lost or repeated
// item.ready is high whenever the output register is empty or being taken
module quaternion_vector_rotation_top #(
  parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  qvr_in_if.sink    item,
  qvr_out_if.source result
);
  import qvr_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int PW   = 2 * W;          // quaternion product
  localparam int CW   = 2 * W + 2;      // rotation matrix entry
  localparam int MW   = CW + W;         // matrix entry times vector
  localparam int NUMW = 3 * W + 4;      // row dot product
  localparam int QW   = W + 2;          // doubled quotient
  localparam int DIVL = W + 3;          // divider latency
  localparam int LAT  = DIVL + 8;       // total latency

  // product slots
  localparam int P_WW = 0;
  localparam int P_XX = 1;
  localparam int P_YY = 2;
  localparam int P_ZZ = 3;
  localparam int P_XY = 4;
  localparam int P_XZ = 5;
  localparam int P_YZ = 6;
  localparam int P_WX = 7;
  localparam int P_WY = 8;
  localparam int P_WZ = 9;
  localparam int NP   = 10;

  logic en;
  logic [LAT-1:0] vld;

  // global advance: every stage moves when the output slot frees up
  assign en          = !vld[LAT-1] || result.ready;
  assign item.ready  = en;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item.valid};
    end
  end

  // stage 0: input capture
  logic signed [W-1:0] qw0, qx0, qy0, qz0;
  logic signed [W-1:0] vec0 [3];
  logic signed [W-1:0] vec1 [3];
  logic signed [W-1:0] vec2 [3];
  logic signed [W-1:0] vec3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      qw0     <= item.quat_w;
      qx0     <= item.quat_x;
      qy0     <= item.quat_y;
      qz0     <= item.quat_z;
      vec0[0] <= item.vec_x;
      vec0[1] <= item.vec_y;
      vec0[2] <= item.vec_z;
      vec1    <= vec0;
      vec2    <= vec1;
      vec3    <= vec2;
    end
  end

  // stages 1-2: the ten second-degree products of q
  logic signed [W-1:0]  opa [NP];
  logic signed [W-1:0]  opb [NP];
  logic signed [PW-1:0] prod [NP];

  always_comb begin
    opa[P_WW] = qw0; opb[P_WW] = qw0;
    opa[P_XX] = qx0; opb[P_XX] = qx0;
    opa[P_YY] = qy0; opb[P_YY] = qy0;
    opa[P_ZZ] = qz0; opb[P_ZZ] = qz0;
    opa[P_XY] = qx0; opb[P_XY] = qy0;
    opa[P_XZ] = qx0; opb[P_XZ] = qz0;
    opa[P_YZ] = qy0; opb[P_YZ] = qz0;
    opa[P_WX] = qw0; opb[P_WX] = qx0;
    opa[P_WY] = qw0; opb[P_WY] = qy0;
    opa[P_WZ] = qw0; opb[P_WZ] = qz0;
  end

  for (genvar i = 0; i < NP; i++) begin : g_qmul
    qvr_mul #(.AW(W), .BW(W)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (opa[i]),
      .b   (opb[i]),
      .p   (prod[i])
    );
  end

  // stage 3: squared norm and the transposed rotation matrix
  logic signed [CW-1:0] e [NP];
  logic signed [CW-1:0] c_next [3][3];
  logic signed [CW-1:0] n2_sum;
  logic signed [CW-1:0] cm [3][3];
  logic [2*W:0] n2_3, n2_4, n2_5, n2_6;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      e[i] = CW'(prod[i]);
    end
    n2_sum       = e[P_WW] + e[P_XX] + e[P_YY] + e[P_ZZ];
    c_next[0][0] = e[P_WW] + e[P_XX] - e[P_YY] - e[P_ZZ];
    c_next[0][1] = (e[P_XY] + e[P_WZ]) <<< 1;
    c_next[0][2] = (e[P_XZ] - e[P_WY]) <<< 1;
    c_next[1][0] = (e[P_XY] - e[P_WZ]) <<< 1;
    c_next[1][1] = e[P_WW] + e[P_YY] - e[P_XX] - e[P_ZZ];
    c_next[1][2] = (e[P_YZ] + e[P_WX]) <<< 1;
    c_next[2][0] = (e[P_XZ] + e[P_WY]) <<< 1;
    c_next[2][1] = (e[P_YZ] - e[P_WX]) <<< 1;
    c_next[2][2] = e[P_WW] + e[P_ZZ] - e[P_XX] - e[P_YY];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm   <= c_next;
      n2_3 <= n2_sum[2*W:0];
      n2_4 <= n2_3;
      n2_5 <= n2_4;
    end
  end

  // stages 4-5: matrix entry times vector component
  logic signed [MW-1:0] mp [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      qvr_mul #(.AW(CW), .BW(W)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (cm[r][j]),
        .b   (vec3[j]),
        .p   (mp[r][j])
      );
    end
  end

  // stage 6: row sums, zero-norm detect
  logic signed [NUMW-1:0] num6 [3];
  logic                   zq6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        num6[r] <= NUMW'(mp[r][0]) + NUMW'(mp[r][1]) + NUMW'(mp[r][2]);
      end
      n2_6 <= n2_5;
      zq6  <= (n2_5 == '0);
    end
  end

  // divider pipelines, zero flag travels alongside
  logic [QW-1:0] quo [3];
  logic          qneg [3];
  logic          zdly [DIVL];

  for (genvar r = 0; r < 3; r++) begin : g_div
    qvr_div #(.W(W)) u_div (
      .clk (clk),
      .en  (en),
      .num (num6[r]),
      .den (n2_6),
      .quo (quo[r]),
      .neg (qneg[r])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zdly[0] <= zq6;
      for (int i = 1; i < DIVL; i++) begin
        zdly[i] <= zdly[i-1];
      end
    end
  end

  // output stage: round half away from zero, then clip
  localparam logic [W:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};

  logic [QW-1:0]       qinc [3];
  logic [W:0]          rnd  [3];
  logic signed [W-1:0] val  [3];
  logic [2:0]          clip;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      qinc[r] = quo[r] + QW'(1);
      rnd[r]  = qinc[r][QW-1:1];
      clip[r] = 1'b0;
      if (qneg[r]) begin
        if (rnd[r] > NEG_LIM) begin
          clip[r] = 1'b1;
          val[r]  = $signed(NEG_LIM[W-1:0]);
        end else begin
          val[r]  = $signed(W'(-rnd[r]));
        end
      end else begin
        if (rnd[r] > POS_LIM) begin
          clip[r] = 1'b1;
          val[r]  = $signed(POS_LIM[W-1:0]);
        end else begin
          val[r]  = $signed(rnd[r][W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zdly[DIVL-1]) begin
        result.out_x     <= '0;
        result.out_y     <= '0;
        result.out_z     <= '0;
        result.saturated <= 1'b0;
        result.zero_quat <= 1'b1;
      end else begin
        result.out_x     <= val[0];
        result.out_y     <= val[1];
        result.out_z     <= val[2];
        result.saturated <= |clip;
        result.zero_quat <= 1'b0;
      end
    end
  end

endmodule

@@ design/qvr_mul.sv @@
// two-stage signed multiplier built from slice partial products
// depends on qvr_pkg for the slice width
module qvr_mul #(
  parameter int AW = qvr_pkg::DATA_WIDTH_DEF,
  parameter int BW = qvr_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import qvr_pkg::*;

  localparam int CH  = MUL_CHUNK;
  localparam int NA  = (AW + CH - 1) / CH;
  localparam int NB  = (BW + CH - 1) / CH;
  localparam int XA  = NA * CH;
  localparam int XB  = NB * CH;
  localparam int SW  = XA + XB + 2;
  localparam int PPW = 2 * CH + 2;

  logic signed [XA-1:0]  ax;
  logic signed [XB-1:0]  bx;
  logic signed [PPW-1:0] pp [NA*NB];
  logic signed [SW-1:0]  acc;

  assign ax = XA'(a);
  assign bx = XB'(b);

  // low slices are unsigned, the top slice carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      logic signed [CH:0] ac;
      logic signed [CH:0] bc;
      if (i == NA - 1) begin : g_as
        assign ac = $signed({ax[XA-1], ax[i*CH +: CH]});
      end else begin : g_au
        assign ac = $signed({1'b0, ax[i*CH +: CH]});
      end
      if (j == NB - 1) begin : g_bs
        assign bc = $signed({bx[XB-1], bx[j*CH +: CH]});
      end else begin : g_bu
        assign bc = $signed({1'b0, bx[j*CH +: CH]});
      end
      always_ff @(posedge clk) begin
        if (en) pp[i*NB+j] <= ac * bc;
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp[i*NB+j]) <<< (CH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= acc[AW+BW-1:0];
  end

endmodule

@@ design/qvr_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// returns floor(2*|num|/den) and the sign of num; depends on qvr_pkg
module qvr_div #(
  parameter int W = qvr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [3*W+3:0] num,
  input  logic        [2*W:0]   den,
  output logic        [W+1:0]   quo,
  output logic                  neg
);
  import qvr_pkg::*;

  localparam int NUMW = 3 * W + 4;
  localparam int RW   = NUMW + 1;
  localparam int QW   = W + 2;
  localparam int DW   = 2 * W + 1;

  logic [RW-1:0] rem [QW+1];
  logic [DW-1:0] dd  [QW+1];
  logic [QW-1:0] qq  [QW+1];
  logic          ng  [QW+1];
  logic [NUMW-1:0] mag;

  assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

  // magnitude stage, doubled for the rounding bit
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {mag, 1'b0};
      dd[0]  <= den;
      qq[0]  <= '0;
      ng[0]  <= num[NUMW-1];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [RW-1:0] sh;
    assign sh = RW'(dd[s]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[s+1] <= dd[s];
        ng[s+1] <= ng[s];
        if (rem[s] >= sh) begin
          rem[s+1] <= rem[s] - sh;
          qq[s+1]  <= qq[s] | (QW'(1) << K);
        end else begin
          rem[s+1] <= rem[s];
          qq[s+1]  <= qq[s];
        end
      end
    end
  end

  assign quo = qq[QW];
  assign neg = ng[QW];

endmodule

@@ design/qvr_checker.sv @@
// port-level checks for the quaternion vector rotation block, with bind
// depends on qvr_pkg and quaternion_vector_rotation_top
module qvr_checker #(
  parameter int W = qvr_pkg::DATA_WIDTH_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] out_x,
  input logic signed [W-1:0] out_y,
  input logic signed [W-1:0] out_z,
  input logic                saturated,
  input logic                zero_quat
);
  import qvr_pkg::*;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  // zero quaternion gives an all-zero, unclipped result
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_quat |-> out_x == '0 && out_y == '0 && out_z == '0 && !saturated)
    else $error("zero quaternion result not cleared");

  // a clipped result shows at least one component at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      !zero_quat && (out_x == SMAX || out_x == SMIN || out_y == SMAX ||
                     out_y == SMIN || out_z == SMAX || out_z == SMIN))
    else $error("saturated flag without a clipped component");

  // an empty output slot never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // input is taken only when the output side can move
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(saturated) && $stable(zero_quat))
    else $error("stalled result changed");

endmodule

bind quaternion_vector_rotation_top qvr_checker #(.W(DATA_WIDTH)) u_qvr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_x     (result.out_x),
  .out_y     (result.out_y),
  .out_z     (result.out_z),
  .saturated (result.saturated),
  .zero_quat (result.zero_quat)
);
